### sv/gotpa_pkg.sv
package gotpa_pkg;

    localparam int TILE_ROWS = 4;
    localparam int TILE_COLS = 8;
    localparam int ROW_W     = 2;
    localparam int COLS_W    = 4;
    localparam int FMA_LAT   = 6;
    localparam int IQ_DEPTH  = 2;
    localparam int IQ_AW     = $clog2(IQ_DEPTH);
    localparam int IQ_CW     = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 2;
    localparam int OQ_AW     = $clog2(OQ_DEPTH);
    localparam int OQ_CW     = $clog2(OQ_DEPTH + 1);

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_ACC   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    localparam logic [63:0] FP_ONE = 64'h3FF0000000000000;
    localparam logic [63:0] FP_NAN = 64'h7FF8000000000000;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  row;
        logic [3:0]  cols_valid;
        logic [63:0] value_0;
        logic [63:0] value_1;
        logic [63:0] value_2;
        logic [63:0] value_3;
        logic [63:0] value_4;
        logic [63:0] value_5;
        logic [63:0] value_6;
        logic [63:0] value_7;
    } item_t;

    typedef struct packed {
        logic [1:0]  out_row;
        logic [63:0] sum_0;
        logic [63:0] sum_1;
        logic [63:0] sum_2;
        logic [63:0] sum_3;
        logic [63:0] sum_4;
        logic [63:0] sum_5;
        logic [63:0] sum_6;
        logic [63:0] sum_7;
        logic        tile_done;
    } result_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [ROW_W-1:0]            row;
        logic [COLS_W-1:0]           cols;
        logic [TILE_COLS-1:0][63:0]  vals;
    } job_t;

    typedef struct packed {
        logic             valid;
        logic             flush;
        logic [ROW_W-1:0] row;
    } wb_t;

endpackage

### sv/gotpa_fma.sv
module gotpa_fma (
    input  logic        clk,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    input  logic [63:0] op_c,
    input  logic        pass,
    output logic [63:0] res
);
    import gotpa_pkg::*;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic               eff_sub;
        logic [53:0]        pp_ll;
        logic [52:0]        pp_lh;
        logic [52:0]        pp_hl;
        logic [51:0]        pp_hh;
        logic [52:0]        mc;
        logic [7:0]         shamt;
        logic signed [12:0] e0;
    } s1_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sp;
        logic               sc;
        logic               eff_sub;
        logic [163:0]       pw;
        logic [163:0]       cj;
        logic signed [12:0] e0;
    } s2_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sign;
        logic [163:0]       mag;
        logic signed [12:0] e0;
    } s3_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sign;
        logic               zero;
        logic               normal;
        logic [163:0]       mag;
        logic signed [12:0] sh;
        logic signed [12:0] biased;
    } s4_t;

    typedef struct packed {
        logic               spec;
        logic [63:0]        spec_val;
        logic               sign;
        logic               zero;
        logic               normal;
        logic [53:0]        mant;
        logic               g;
        logic               st;
        logic signed [12:0] biased;
    } s5_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    logic [63:0] res_reg, res_next;

    always_comb
    begin
        logic        sa, sb, sc;
        logic [10:0] xa, xb, xc;
        logic [51:0] fa, fb, fc;
        logic        za, zb, zc, nan_any;
        logic [52:0] ma, mb;
        logic signed [13:0] ea, eb, ec, s_raw;
        sa = op_a[63];
        sb = op_b[63];
        sc = op_c[63];
        xa = op_a[62:52];
        xb = op_b[62:52];
        xc = op_c[62:52];
        fa = op_a[51:0];
        fb = op_b[51:0];
        fc = op_c[51:0];
        za = (xa == 11'd0) && (fa == 52'd0);
        zb = (xb == 11'd0) && (fb == 52'd0);
        zc = (xc == 11'd0) && (fc == 52'd0);
        nan_any = ((xa == 11'h7FF) && (fa != 52'd0)) || ((xb == 11'h7FF) && (fb != 52'd0))
                  || ((xc == 11'h7FF) && (fc != 52'd0));
        ea = {3'd0, (xa == 11'd0) ? 11'd1 : xa};
        eb = {3'd0, (xb == 11'd0) ? 11'd1 : xb};
        ec = {3'd0, (xc == 11'd0) ? 11'd1 : xc};
        s_raw = ea + eb - ec - 14'sd967;
        s1_next.sp = sa ^ sb;
        s1_next.sc = sc;
        s1_next.eff_sub = sa ^ sb ^ sc;
        s1_next.spec = 1'b1;
        s1_next.spec_val = op_c;
        if (pass)
        begin
            s1_next.spec_val = op_a;
        end
        else if (nan_any)
        begin
            s1_next.spec_val = FP_NAN;
        end
        else if ((xa == 11'h7FF) || (xb == 11'h7FF))
        begin
            if (za || zb || ((xc == 11'h7FF) && (sc != (sa ^ sb))))
                s1_next.spec_val = FP_NAN;
            else
                s1_next.spec_val = {sa ^ sb, 11'h7FF, 52'd0};
        end
        else if (xc == 11'h7FF)
        begin
            s1_next.spec_val = op_c;
        end
        else if (za || zb)
        begin
            if (zc)
                s1_next.spec_val = ((sa ^ sb) == sc) ? {sc, 63'd0} : 64'd0;
            else
                s1_next.spec_val = op_c;
        end
        else if ((s_raw < 14'sd0) && !zc)
        begin
            // The product lies wholly below half an ulp of the addend.
            s1_next.spec_val = op_c;
        end
        else
        begin
            s1_next.spec = 1'b0;
        end
        ma = {xa != 11'd0, fa};
        mb = {xb != 11'd0, fb};
        s1_next.mc = {xc != 11'd0, fc};
        s1_next.pp_ll = ma[26:0] * mb[26:0];
        s1_next.pp_lh = ma[26:0] * mb[52:27];
        s1_next.pp_hl = ma[52:27] * mb[26:0];
        s1_next.pp_hh = ma[52:27] * mb[52:27];
        if (zc)
        begin
            s1_next.shamt = 8'd164;
            s1_next.e0 = 13'(ea + eb - 14'sd2153);
        end
        else if (s_raw < 14'sd0)
        begin
            s1_next.shamt = 8'd0;
            s1_next.e0 = 13'(ec - 14'sd1186);
        end
        else
        begin
            s1_next.shamt = (s_raw > 14'sd164) ? 8'd164 : s_raw[7:0];
            s1_next.e0 = 13'(ea + eb - 14'sd2153);
        end
    end

    always_comb
    begin
        logic [105:0] p;
        logic [163:0] cfull, csh;
        logic         lost;
        p = (106'(s1_reg.pp_hh) << 54) + (106'(s1_reg.pp_lh) << 27)
            + (106'(s1_reg.pp_hl) << 27) + 106'(s1_reg.pp_ll);
        cfull = {s1_reg.mc, 111'd0};
        csh = cfull >> s1_reg.shamt;
        lost = |(cfull & ~({164{1'b1}} << s1_reg.shamt));
        s2_next.spec = s1_reg.spec;
        s2_next.spec_val = s1_reg.spec_val;
        s2_next.sp = s1_reg.sp;
        s2_next.sc = s1_reg.sc;
        s2_next.eff_sub = s1_reg.eff_sub;
        s2_next.pw = {55'd0, p, 3'd0};
        s2_next.cj = csh | {163'd0, lost};
        s2_next.e0 = s1_reg.e0;
    end

    always_comb
    begin
        logic [164:0] sum, dpc, dcp;
        sum = {1'b0, s2_reg.pw} + {1'b0, s2_reg.cj};
        dpc = {1'b0, s2_reg.pw} - {1'b0, s2_reg.cj};
        dcp = {1'b0, s2_reg.cj} - {1'b0, s2_reg.pw};
        s3_next.spec = s2_reg.spec;
        s3_next.spec_val = s2_reg.spec_val;
        s3_next.e0 = s2_reg.e0;
        if (!s2_reg.eff_sub)
        begin
            s3_next.mag = sum[163:0];
            s3_next.sign = s2_reg.sp;
        end
        else if (dpc[164])
        begin
            s3_next.mag = dcp[163:0];
            s3_next.sign = s2_reg.sc;
        end
        else
        begin
            s3_next.mag = dpc[163:0];
            s3_next.sign = s2_reg.sp;
        end
    end

    always_comb
    begin
        logic [7:0]         q;
        logic signed [12:0] e_msb;
        q = 8'd0;
        for (int i = 0; i < 164; i++)
        begin
            if (s3_reg.mag[i])
                q = 8'(i);
        end
        e_msb = s3_reg.e0 + 13'(q);
        s4_next.spec = s3_reg.spec;
        s4_next.spec_val = s3_reg.spec_val;
        s4_next.zero = (s3_reg.mag == 164'd0);
        s4_next.sign = s3_reg.sign && (s3_reg.mag != 164'd0);
        s4_next.mag = s3_reg.mag;
        s4_next.normal = (e_msb >= -13'sd1022);
        s4_next.sh = s4_next.normal ? (13'(q) - 13'sd52) : (-13'sd1074 - s3_reg.e0);
        s4_next.biased = e_msb + 13'sd1023;
    end

    always_comb
    begin
        logic [12:0]  neg_sh;
        logic [7:0]   shc;
        logic [164:0] ext;
        neg_sh = 13'(-s4_reg.sh);
        shc = 8'd0;
        ext = '0;
        s5_next.spec = s4_reg.spec;
        s5_next.spec_val = s4_reg.spec_val;
        s5_next.sign = s4_reg.sign;
        s5_next.zero = s4_reg.zero;
        s5_next.normal = s4_reg.normal;
        s5_next.biased = s4_reg.biased;
        if (s4_reg.sh <= 13'sd0)
        begin
            s5_next.mant = s4_reg.mag[53:0] << neg_sh[5:0];
            s5_next.g = 1'b0;
            s5_next.st = 1'b0;
        end
        else
        begin
            shc = (s4_reg.sh > 13'sd165) ? 8'd165 : s4_reg.sh[7:0];
            ext = {s4_reg.mag, 1'b0} >> shc;
            s5_next.mant = ext[54:1];
            s5_next.g = ext[0];
            s5_next.st = |(s4_reg.mag & ~({164{1'b1}} << (shc - 8'd1)));
        end
    end

    always_comb
    begin
        logic [53:0]        mr;
        logic signed [12:0] b2;
        mr = s5_reg.mant + 54'(s5_reg.g & (s5_reg.st | s5_reg.mant[0]));
        b2 = mr[53] ? (s5_reg.biased + 13'sd1) : s5_reg.biased;
        if (s5_reg.spec)
            res_next = s5_reg.spec_val;
        else if (s5_reg.zero)
            res_next = 64'd0;
        else if (s5_reg.normal)
        begin
            if (b2 >= 13'sd2047)
                res_next = {s5_reg.sign, 11'h7FF, 52'd0};
            else
                res_next = {s5_reg.sign, b2[10:0], mr[51:0]};
        end
        else
            res_next = {s5_reg.sign, 9'd0, mr};
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
        s3_reg <= s3_next;
        s4_reg <= s4_next;
        s5_reg <= s5_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### sv/gotpa_front.sv
module gotpa_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  gotpa_pkg::item_t item,
    output logic             job_valid,
    input  logic             job_ready,
    output gotpa_pkg::job_t  job
);
    import gotpa_pkg::*;

    job_t             q_reg [IQ_DEPTH];
    logic [IQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IQ_CW-1:0] cnt_reg, cnt_next;
    logic             push, pop;
    job_t             new_job;

    assign item_ready = (cnt_reg != IQ_CW'(IQ_DEPTH));
    assign push = item_valid && item_ready && (item.action != ACT_NOP);
    assign job_valid = (cnt_reg != '0);
    assign pop = job_valid && job_ready;
    assign job = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_job.kind = item.action;
        new_job.row = item.row;
        new_job.cols = (item.cols_valid > COLS_W'(TILE_COLS)) ? COLS_W'(TILE_COLS)
                                                              : item.cols_valid;
        new_job.vals[0] = item.value_0;
        new_job.vals[1] = item.value_1;
        new_job.vals[2] = item.value_2;
        new_job.vals[3] = item.value_3;
        new_job.vals[4] = item.value_4;
        new_job.vals[5] = item.value_5;
        new_job.vals[6] = item.value_6;
        new_job.vals[7] = item.value_7;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == IQ_AW'(IQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == IQ_AW'(IQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        cnt_next = cnt_reg + IQ_CW'(push) - IQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= new_job;
    end

endmodule

### sv/gotpa_back.sv
module gotpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  gotpa_pkg::job_t    job,
    output logic               result_valid,
    input  logic               result_ready,
    output gotpa_pkg::result_t result
);
    import gotpa_pkg::*;

    logic [63:0]      a_col_reg [TILE_ROWS];
    logic [63:0]      acc_reg [TILE_ROWS][TILE_COLS];
    logic [TILE_ROWS-1:0] busy_reg, busy_next;
    logic [ROW_W-1:0] step_reg, step_next;
    wb_t              meta_reg [FMA_LAT];
    wb_t              meta_in, wb;
    result_t          oq_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wr_reg, oq_wr_next;
    logic [OQ_AW-1:0] oq_rd_reg, oq_rd_next;
    logic [OQ_CW-1:0] oq_cnt_reg, oq_cnt_next;
    logic [OQ_CW-1:0] pend_reg, pend_next;
    logic [63:0]      op_a [TILE_COLS];
    logic [63:0]      op_b [TILE_COLS];
    logic [63:0]      op_c [TILE_COLS];
    logic [TILE_COLS-1:0] pass;
    logic [63:0]      res [TILE_COLS];
    logic [ROW_W-1:0] sel_row;
    logic             is_flush, issue, room, load, oq_push, oq_pop;
    result_t          wb_result;

    assign is_flush = (job.kind == ACT_FLUSH);
    assign sel_row = is_flush ? job.row : step_reg;
    assign room = ((OQ_CW + 1)'(oq_cnt_reg) + (OQ_CW + 1)'(pend_reg)) < (OQ_CW + 1)'(OQ_DEPTH);
    assign wb = meta_reg[FMA_LAT-1];
    assign oq_push = wb.valid && wb.flush;
    assign result_valid = (oq_cnt_reg != '0);
    assign oq_pop = result_valid && result_ready;
    assign result = oq_reg[oq_rd_reg];

    always_comb
    begin
        issue = 1'b0;
        job_ready = 1'b0;
        load = 1'b0;
        if (job_valid)
        begin
            case (job.kind)
                ACT_LOAD:
                begin
                    load = 1'b1;
                    job_ready = 1'b1;
                end
                ACT_ACC:
                begin
                    issue = !busy_reg[step_reg];
                    job_ready = issue && (step_reg == ROW_W'(TILE_ROWS - 1));
                end
                ACT_FLUSH:
                begin
                    issue = !busy_reg[job.row] && room;
                    job_ready = issue;
                end
                default:
                begin
                    job_ready = 1'b1;
                end
            endcase
        end
        step_next = step_reg;
        if (issue && !is_flush)
            step_next = (step_reg == ROW_W'(TILE_ROWS - 1)) ? '0 : step_reg + 1'b1;
        meta_in.valid = issue;
        meta_in.flush = is_flush;
        meta_in.row = sel_row;
        busy_next = busy_reg;
        if (wb.valid)
            busy_next[wb.row] = 1'b0;
        if (issue)
            busy_next[sel_row] = 1'b1;
        pend_next = pend_reg + OQ_CW'(issue && is_flush) - OQ_CW'(oq_push);
        oq_cnt_next = oq_cnt_reg + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
        oq_wr_next = oq_wr_reg;
        oq_rd_next = oq_rd_reg;
        if (oq_push)
            oq_wr_next = (oq_wr_reg == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_wr_reg + 1'b1;
        if (oq_pop)
            oq_rd_next = (oq_rd_reg == OQ_AW'(OQ_DEPTH - 1)) ? '0 : oq_rd_reg + 1'b1;
        wb_result.out_row = wb.row;
        wb_result.sum_0 = res[0];
        wb_result.sum_1 = res[1];
        wb_result.sum_2 = res[2];
        wb_result.sum_3 = res[3];
        wb_result.sum_4 = res[4];
        wb_result.sum_5 = res[5];
        wb_result.sum_6 = res[6];
        wb_result.sum_7 = res[7];
        wb_result.tile_done = (wb.row == ROW_W'(TILE_ROWS - 1));
    end

    for (genvar j = 0; j < TILE_COLS; j++)
    begin : g_lane
        always_comb
        begin
            op_c[j] = acc_reg[sel_row][j];
            if (is_flush)
            begin
                op_a[j] = job.vals[j];
                op_b[j] = FP_ONE;
                pass[j] = (COLS_W'(j) >= job.cols);
            end
            else
            begin
                op_a[j] = a_col_reg[sel_row];
                op_b[j] = job.vals[j];
                pass[j] = 1'b0;
            end
        end

        gotpa_fma u_fma (
            .clk  (clk),
            .op_a (op_a[j]),
            .op_b (op_b[j]),
            .op_c (op_c[j]),
            .pass (pass[j]),
            .res  (res[j])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < TILE_ROWS; r++)
            begin
                a_col_reg[r] <= '0;
                for (int j = 0; j < TILE_COLS; j++)
                    acc_reg[r][j] <= '0;
            end
            for (int i = 0; i < FMA_LAT; i++)
                meta_reg[i] <= '0;
            busy_reg <= '0;
            step_reg <= '0;
            oq_wr_reg <= '0;
            oq_rd_reg <= '0;
            oq_cnt_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                for (int r = 0; r < TILE_ROWS; r++)
                    a_col_reg[r] <= job.vals[r];
            end
            if (wb.valid)
            begin
                for (int j = 0; j < TILE_COLS; j++)
                    acc_reg[wb.row][j] <= wb.flush ? 64'd0 : res[j];
            end
            meta_reg[0] <= meta_in;
            for (int i = 1; i < FMA_LAT; i++)
                meta_reg[i] <= meta_reg[i-1];
            busy_reg <= busy_next;
            step_reg <= step_next;
            oq_wr_reg <= oq_wr_next;
            oq_rd_reg <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_reg[oq_wr_reg] <= wb_result;
    end

endmodule

### sv/gemm_tile_outer_product_accumulate_core.sv
// Binary64 4x8 outer-product tile engine with one input and one output channel.
// Each input beat is a load of an A column, an accumulate of a B row, a flush
// of one C row or a no-op, which is dropped; only a flush produces an output
// beat, carrying C plus the row's accumulators on the valid lanes and C
// unchanged on the others. Beats other than no-ops enter a two-entry queue;
// the back end pops them in order and issues one tile row per cycle, while that
// row is not busy, into eight six-stage fused multiply-add lanes. A load only
// captures the A column. An accumulate issues its four rows in order, but a row
// cannot be issued again until its previous update has been written back, so
// back-to-back accumulates stall until the rows they need are free again.
// A flush needs its row idle and a free output slot.
// Results wait in a two-entry output queue. When the receiver stalls, flushes
// stop issuing once that queue and the flushes in flight would fill it, and the
// input queue then backs up; nothing is dropped.
// Reset clears the A column, all accumulators to positive zero and both queues.
module gemm_tile_outer_product_accumulate_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  gotpa_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_ready,
    output gotpa_pkg::result_t result
);
    import gotpa_pkg::*;

    logic job_valid;
    logic job_ready;
    job_t job;

    gotpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    gotpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### sv/gotpa_checker.sv
module gotpa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input gotpa_pkg::result_t result
);
    import gotpa_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("Output beat changed while stalled.");

    a_tile_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.tile_done == (result.out_row == ROW_W'(TILE_ROWS - 1))))
        else $error("Tile done flag does not match the row.");

    a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !result_valid)
        else $error("Output beat right after reset.");

endmodule

bind gemm_tile_outer_product_accumulate_core gotpa_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### tb/gemm_tile_outer_product_accumulate_core_test.sv
module gemm_tile_outer_product_accumulate_core_test;
    import gotpa_pkg::*;

    localparam logic [63:0] POS_INF = 64'h7FF0000000000000;
    localparam logic [63:0] NEG_INF = 64'hFFF0000000000000;
    localparam logic [63:0] NEG_ZERO = 64'h8000000000000000;
    localparam logic [63:0] MAX_NORM = 64'h7FEFFFFFFFFFFFFF;
    localparam logic [63:0] MIN_SUB = 64'h0000000000000001;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;

    logic [63:0] a_regs [TILE_ROWS];
    logic [63:0] acc_regs [TILE_ROWS][TILE_COLS];
    result_t expected_rows [$];
    int error_count;
    int idle_cycles;
    bit stimulus_done;

    gemm_tile_outer_product_accumulate_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int top_bit(logic [127:0] x);
        int i;
        for (i = 127; i > 0; i--)
        begin
            if (x[i])
            begin
                return i;
            end
        end
        return 0;
    endfunction

    function automatic logic [63:0] round_to_double(logic s, logic [127:0] r, int e);
        int p;
        int big_e;
        int sh;
        int biased;
        bit normal;
        logic [127:0] rem;
        logic [127:0] half;
        logic [63:0] q;
        p = top_bit(r);
        big_e = e + p;
        normal = big_e >= -1022;
        sh = normal ? p - 52 : -1074 - e;
        if (sh <= 0)
        begin
            q = 64'(r << (-sh));
        end
        else if (sh >= 128)
        begin
            return {s, 63'd0};
        end
        else
        begin
            q = 64'(r >> sh);
            rem = r - ((r >> sh) << sh);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 1;
            end
        end
        if (normal)
        begin
            biased = big_e + 1023;
            if (q == 64'h0020000000000000)
            begin
                q = q >> 1;
                biased++;
            end
            if (biased >= 2047)
            begin
                return {s, 63'h7FF0000000000000};
            end
            return {s, 11'(biased), q[51:0]};
        end
        return {s, q[62:0]};
    endfunction

    // Computes a*b + c with a single rounding, treating every NaN as the default NaN.
    function automatic logic [63:0] fma_double(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] c);
        logic sp;
        logic bs;
        logic ss;
        logic [10:0] xa;
        logic [10:0] xb;
        logic [10:0] xc;
        bit za;
        bit zb;
        bit zc;
        logic [127:0] pw;
        logic [127:0] cw;
        logic [127:0] big;
        logic [127:0] lesser;
        logic [127:0] shifted;
        int pe;
        int ce;
        int be;
        int se;
        int sh;
        sp = a[63] ^ b[63];
        xa = a[62:52];
        xb = b[62:52];
        xc = c[62:52];
        za = a[62:0] == 0;
        zb = b[62:0] == 0;
        zc = c[62:0] == 0;
        if ((&xa && a[51:0] != 0) || (&xb && b[51:0] != 0) || (&xc && c[51:0] != 0))
        begin
            return FP_NAN;
        end
        if (&xa || &xb)
        begin
            if (za || zb || (&xc && c[63] != sp))
            begin
                return FP_NAN;
            end
            return {sp, 63'h7FF0000000000000};
        end
        if (&xc)
        begin
            return c;
        end
        if (za || zb)
        begin
            if (zc)
            begin
                return (sp == c[63]) ? {sp, 63'd0} : 64'd0;
            end
            return c;
        end
        pw = {64'd0, 11'd0, xa != 0, a[51:0]} * {64'd0, 11'd0, xb != 0, b[51:0]};
        pe = ((xa != 0 ? int'(xa) : 1) - 1075) + ((xb != 0 ? int'(xb) : 1) - 1075);
        sh = 125 - top_bit(pw);
        pw = pw << sh;
        pe -= sh;
        if (zc)
        begin
            return round_to_double(sp, pw, pe);
        end
        cw = {64'd0, 11'd0, xc != 0, c[51:0]};
        ce = (xc != 0 ? int'(xc) : 1) - 1075;
        sh = 125 - top_bit(cw);
        cw = cw << sh;
        ce -= sh;
        if (pe >= ce)
        begin
            big = pw; be = pe; bs = sp; lesser = cw; se = ce; ss = c[63];
        end
        else
        begin
            big = cw; be = ce; bs = c[63]; lesser = pw; se = pe; ss = sp;
        end
        sh = be - se;
        if (sh >= 128)
        begin
            lesser = (lesser != 0) ? 128'd1 : 128'd0;
        end
        else if (sh > 0)
        begin
            shifted = lesser >> sh;
            lesser = shifted | 128'((shifted << sh) != lesser);
        end
        if (bs == ss)
        begin
            return round_to_double(bs, big + lesser, be);
        end
        if (big == lesser)
        begin
            return 64'd0;
        end
        if (big > lesser)
        begin
            return round_to_double(bs, big - lesser, be);
        end
        return round_to_double(ss, lesser - big, be);
    endfunction

    function automatic logic [63:0] lane_of(item_t it, int j);
        logic [7:0][63:0] v;
        v = {it.value_7, it.value_6, it.value_5, it.value_4,
             it.value_3, it.value_2, it.value_1, it.value_0};
        return v[j];
    endfunction

    // Updates the tile state for one beat and queues the flushed row, if any.
    task automatic apply_tile_beat(item_t it);
        logic [7:0][63:0] sums;
        int ncols;
        result_t res;
        case (it.action)
            ACT_LOAD:
            begin
                for (int r = 0; r < TILE_ROWS; r++)
                begin
                    a_regs[r] = lane_of(it, r);
                end
            end
            ACT_ACC:
            begin
                for (int r = 0; r < TILE_ROWS; r++)
                begin
                    for (int j = 0; j < TILE_COLS; j++)
                    begin
                        acc_regs[r][j] = fma_double(a_regs[r], lane_of(it, j), acc_regs[r][j]);
                    end
                end
            end
            ACT_FLUSH:
            begin
                ncols = (it.cols_valid > TILE_COLS) ? TILE_COLS : int'(it.cols_valid);
                for (int j = 0; j < 8; j++)
                begin
                    sums[j] = lane_of(it, j);
                end
                res.tile_done = 1'b0;
                if (it.row < TILE_ROWS)
                begin
                    for (int j = 0; j < TILE_COLS; j++)
                    begin
                        if (j < ncols)
                        begin
                            sums[j] = fma_double(sums[j], FP_ONE, acc_regs[it.row][j]);
                        end
                        acc_regs[it.row][j] = 64'd0;
                    end
                    res.tile_done = (it.row == TILE_ROWS - 1);
                end
                res.out_row = it.row;
                {res.sum_7, res.sum_6, res.sum_5, res.sum_4,
                 res.sum_3, res.sum_2, res.sum_1, res.sum_0} = sums;
                expected_rows.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v[62:52] = 11'h7FF;
            1: v[62:52] = 11'h000;
            2: v[62:0] = 63'd0;
            3: v[62:52] = 11'($urandom_range(2030, 2046));
            default: v[62:52] = 11'($urandom_range(990, 1060));
        endcase
        return v;
    endfunction

    function automatic item_t random_beat();
        item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        it.action = (pick < 25) ? ACT_LOAD : (pick < 70) ? ACT_ACC :
                    (pick < 97) ? ACT_FLUSH : ACT_NOP;
        it.row = 2'($urandom);
        it.cols_valid = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
        {it.value_0, it.value_1, it.value_2, it.value_3} =
            {random_double(), random_double(), random_double(), random_double()};
        {it.value_4, it.value_5, it.value_6, it.value_7} =
            {random_double(), random_double(), random_double(), random_double()};
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is accepted.
    task automatic send_beat(item_t it);
        if ($urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        apply_tile_beat(it);
        @(negedge clk);
    endtask

    function automatic item_t make_beat(logic [1:0] act, logic [1:0] r, logic [3:0] c,
                                        logic [63:0] v0, logic [63:0] v1);
        item_t it;
        it = '0;
        it.action = act;
        it.row = r;
        it.cols_valid = c;
        it.value_0 = v0;
        it.value_1 = v1;
        it.value_2 = v0;
        it.value_3 = v1;
        it.value_4 = v0;
        it.value_5 = v1;
        it.value_6 = v0;
        it.value_7 = v1;
        return it;
    endfunction

    item_t directed_beats [$];

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_ready = 1'b0;
        error_count = 0;
        stimulus_done = 1'b0;
        for (int r = 0; r < TILE_ROWS; r++)
        begin
            a_regs[r] = 64'd0;
            for (int j = 0; j < TILE_COLS; j++)
            begin
                acc_regs[r][j] = 64'd0;
            end
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        directed_beats = '{
            make_beat(ACT_FLUSH, 2'd0, 4'd8, FP_ONE, NEG_ZERO),
            make_beat(ACT_LOAD, 2'd0, 4'd0, FP_ONE, MAX_NORM),
            make_beat(ACT_ACC, 2'd0, 4'd0, MAX_NORM, MIN_SUB),
            make_beat(ACT_ACC, 2'd0, 4'd0, MAX_NORM, NEG_INF),
            make_beat(ACT_FLUSH, 2'd0, 4'd15, NEG_ZERO, FP_ONE),
            make_beat(ACT_FLUSH, 2'd1, 4'd3, POS_INF, 64'hFFFFFFFFFFFFFFFF),
            make_beat(ACT_LOAD, 2'd0, 4'd0, POS_INF, 64'd0),
            make_beat(ACT_ACC, 2'd0, 4'd0, 64'd0, FP_ONE),
            make_beat(ACT_NOP, 2'd3, 4'd8, FP_ONE, FP_ONE),
            make_beat(ACT_FLUSH, 2'd2, 4'd0, FP_ONE, FP_NAN),
            make_beat(ACT_FLUSH, 2'd3, 4'd9, FP_ONE, 64'hBFF0000000000000),
            make_beat(ACT_LOAD, 2'd0, 4'd0, 64'h8000000000000001, MIN_SUB),
            make_beat(ACT_ACC, 2'd0, 4'd0, MIN_SUB, 64'h7FE0000000000000),
            make_beat(ACT_FLUSH, 2'd0, 4'd1, 64'h0000000000000000, MAX_NORM),
            make_beat(ACT_FLUSH, 2'd1, 4'd8, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA)
        };
        for (int i = 0; i < directed_beats.size(); i++)
        begin
            send_beat(directed_beats[i]);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_beat(random_beat());
        end
        item_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            result_ready <= ($urandom_range(0, 3) != 0) || ((idle_cycles / 64) % 2 == 1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_rows.size() == 0)
            begin
                report_mismatch("unexpected beat, out_row", 64'(result.out_row), 64'd0);
            end
            else
            begin
                result_t want;
                want = expected_rows.pop_front();
                if (result.out_row != want.out_row)
                    report_mismatch("out_row", 64'(result.out_row), 64'(want.out_row));
                if (result.tile_done != want.tile_done)
                    report_mismatch("tile_done", 64'(result.tile_done), 64'(want.tile_done));
                if (result.sum_0 !== want.sum_0) report_mismatch("sum_0", result.sum_0, want.sum_0);
                if (result.sum_1 !== want.sum_1) report_mismatch("sum_1", result.sum_1, want.sum_1);
                if (result.sum_2 !== want.sum_2) report_mismatch("sum_2", result.sum_2, want.sum_2);
                if (result.sum_3 !== want.sum_3) report_mismatch("sum_3", result.sum_3, want.sum_3);
                if (result.sum_4 !== want.sum_4) report_mismatch("sum_4", result.sum_4, want.sum_4);
                if (result.sum_5 !== want.sum_5) report_mismatch("sum_5", result.sum_5, want.sum_5);
                if (result.sum_6 !== want.sum_6) report_mismatch("sum_6", result.sum_6, want.sum_6);
                if (result.sum_7 !== want.sum_7) report_mismatch("sum_7", result.sum_7, want.sum_7);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (stimulus_done && expected_rows.size() == 0)
            begin
                repeat (40) @(posedge clk);
                if (error_count == 0 && expected_rows.size() == 0)
                begin
                    $display("status: pass");
                end
                else
                begin
                    $display("status: fail");
                end
                $finish;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end
endmodule

### sim.f
sv/gotpa_pkg.sv
sv/gotpa_fma.sv
sv/gotpa_front.sv
sv/gotpa_back.sv
sv/gemm_tile_outer_product_accumulate_core.sv
sv/gotpa_checker.sv
tb/gemm_tile_outer_product_accumulate_core_test.sv
